@@ rtl/core/mzfr_pkg.sv @@
// Shared types and constants for the MIDI zone filter and remap block.
// Depends on nothing; every other file in rtl/core imports it.
package mzfr_pkg;

   localparam int MAX_MSG_LEN = 3;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);
   localparam int MAP_DEPTH   = 128;
   localparam int MAP_ADDR_W  = $clog2(MAP_DEPTH);

   // Input item opcodes.
   localparam logic [1:0] OP_MIDI   = 2'd0;
   localparam logic [1:0] OP_MAP    = 2'd1;
   localparam logic [1:0] OP_PERIOD = 2'd2;

   // High nibbles of MIDI status bytes.
   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_CTRL     = 4'hB;
   localparam logic [3:0] NIB_PROGRAM  = 4'hC;

   localparam logic [1:0] LEN_PROGRAM = 2'd2;
   localparam logic [1:0] LEN_FULL    = 2'd3;

   // Configuration register indexes (byte address is four times the index).
   typedef enum logic [2:0] {
      CSR_ACTIVE    = 3'd0,
      CSR_NOTE_LOW  = 3'd1,
      CSR_NOTE_HIGH = 3'd2,
      CSR_VEL_OVR   = 3'd3,
      CSR_TRANSPOSE = 3'd4,
      CSR_OUT_CHAN  = 3'd5,
      CSR_PROGRAM   = 3'd6
   } csr_index_type;

   // What the back end has to do with a queued transaction.
   typedef enum logic [2:0] {
      KIND_NOTE_ON  = 3'd0,
      KIND_NOTE_OFF = 3'd1,
      KIND_CTRL     = 3'd2,
      KIND_PROGRAM  = 3'd3,
      KIND_PASS     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] status_byte;
      logic [7:0] first_data;
      logic [7:0] second_data;
      logic [3:0] msg_length;
      logic [6:0] map_source;
      logic [6:0] map_target;
   } req_type;

   typedef struct packed {
      logic [7:0] out_status;
      logic [7:0] out_first;
      logic [7:0] out_second;
      logic [1:0] out_length;
   } rsp_type;

   typedef struct packed {
      logic              active;
      logic [6:0]        note_low;
      logic [6:0]        note_high;
      logic [6:0]        velocity_override;
      logic signed [5:0] transpose;
      logic [3:0]        out_channel;
      logic [6:0]        program_cfg;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] status;
      logic [7:0] first;
      logic [7:0] second;
      logic [1:0] length;
   } stage_type;

   typedef struct packed {
      stage_type  item;
      logic [6:0] ctl_num;
   } job_type;

endpackage

@@ rtl/core/mzfr_front.sv @@
// Front end: accepts input transactions, classifies them, owns the controller map
// and the last-program register. Depends on mzfr_pkg.
module mzfr_front import mzfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output job_type q_data
);

   logic                  stage_vld_ff, stage_vld_in;
   stage_type             stage_ff;
   stage_type             stage_in;
   logic [6:0]            last_prog_ff, last_prog_in;
   logic [6:0]            map_mem [MAP_DEPTH];
   logic [MAP_DEPTH-1:0]  map_vld_ff;
   logic [6:0]            map_rd_ff;
   logic                  map_rd_vld_ff;
   logic [6:0]            map_rd_addr_ff;
   logic                  accept;
   logic                  emit;
   logic                  load;
   logic                  map_wr;
   logic                  len_ok;
   logic                  in_range;
   logic [3:0]            nib;

   assign req_stall = stage_vld_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = stage_vld_ff && !q_full;
   assign load      = accept && emit;
   assign map_wr    = accept && (req_data.opcode == OP_MAP);

   always_comb begin
      nib      = req_data.status_byte[7:4];
      len_ok   = (req_data.msg_length != 4'd0) &&
                 (req_data.msg_length <= 4'(MAX_MSG_LEN));
      in_range = (req_data.first_data >= {1'b0, cfg.note_low}) &&
                 (req_data.first_data <= {1'b0, cfg.note_high});
      emit            = 1'b0;
      stage_in.kind   = KIND_PASS;
      stage_in.status = req_data.status_byte;
      stage_in.first  = req_data.first_data;
      stage_in.second = req_data.second_data;
      stage_in.length = req_data.msg_length[1:0];
      last_prog_in    = last_prog_ff;
      case (req_data.opcode)
         OP_MIDI: begin
            if (cfg.active && len_ok) begin
               if (nib == NIB_NOTE_ON || nib == NIB_NOTE_OFF) begin
                  emit = in_range;
                  stage_in.kind = (nib == NIB_NOTE_ON && req_data.second_data != 8'd0) ?
                                  KIND_NOTE_ON : KIND_NOTE_OFF;
               end else if (nib == NIB_CTRL) begin
                  emit = 1'b1;
                  stage_in.kind = KIND_CTRL;
               end else begin
                  // Anything else goes out as is; bytes past the length read as zero.
                  emit = 1'b1;
                  if (req_data.msg_length < 4'd2) begin
                     stage_in.first = 8'd0;
                  end
                  if (req_data.msg_length < 4'd3) begin
                     stage_in.second = 8'd0;
                  end
               end
            end
         end
         OP_PERIOD: begin
            if (cfg.active && (last_prog_ff != cfg.program_cfg)) begin
               emit           = 1'b1;
               stage_in.kind  = KIND_PROGRAM;
               stage_in.first = {1'b0, cfg.program_cfg};
               if (accept) begin
                  last_prog_in = cfg.program_cfg;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         stage_vld_in = 1'b1;
      end else if (q_push) begin
         stage_vld_in = 1'b0;
      end else begin
         stage_vld_in = stage_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         last_prog_ff <= 7'd0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         last_prog_ff <= last_prog_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   // Controller map: an entry never written since reset reads as its own index.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
      end else if (map_wr) begin
         map_vld_ff[req_data.map_source] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (map_wr) begin
         map_mem[req_data.map_source] <= req_data.map_target;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         map_rd_ff      <= map_mem[req_data.first_data[MAP_ADDR_W-1:0]];
         map_rd_vld_ff  <= map_vld_ff[req_data.first_data[MAP_ADDR_W-1:0]];
         map_rd_addr_ff <= req_data.first_data[MAP_ADDR_W-1:0];
      end
   end

   assign q_data.item    = stage_ff;
   assign q_data.ctl_num = map_rd_vld_ff ? map_rd_ff : map_rd_addr_ff;

endmodule

@@ rtl/core/mzfr_queue.sv @@
// Short queue of classified transactions between the front and back ends.
// Depends on mzfr_pkg.
module mzfr_queue import mzfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   job_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");
`endif

endmodule

@@ rtl/core/mzfr_back.sv @@
// Back end: builds the outgoing MIDI message from a queued transaction and
// holds it in the output register. Depends on mzfr_pkg.
module mzfr_back import mzfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_empty,
   input  job_type q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       rsp_vld_ff, rsp_vld_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic [8:0] note_sum;
   logic [6:0] note_out;
   logic [7:0] velocity;

   assign q_pop = !q_empty && (!rsp_vld_ff || !rsp_stall);

   always_comb begin
      // Transpose on a 9-bit two's complement sum, then clamp to 0..127.
      note_sum = {2'b00, q_data.item.first[6:0]} +
                 {{3{cfg.transpose[5]}}, cfg.transpose};
      if (note_sum[8]) begin
         note_out = 7'd0;
      end else if (note_sum[7]) begin
         note_out = 7'd127;
      end else begin
         note_out = note_sum[6:0];
      end
      velocity = (cfg.velocity_override != 7'd0) ?
                 {1'b0, cfg.velocity_override} : q_data.item.second;

      rsp_in.out_status = q_data.item.status;
      rsp_in.out_first  = q_data.item.first;
      rsp_in.out_second = q_data.item.second;
      rsp_in.out_length = q_data.item.length;
      case (q_data.item.kind)
         KIND_NOTE_ON, KIND_NOTE_OFF: begin
            rsp_in.out_status = {(q_data.item.kind == KIND_NOTE_ON) ?
                                 NIB_NOTE_ON : NIB_NOTE_OFF, cfg.out_channel};
            rsp_in.out_first  = {1'b0, note_out};
            rsp_in.out_second = velocity;
            rsp_in.out_length = LEN_FULL;
         end
         KIND_CTRL: begin
            rsp_in.out_status = {NIB_CTRL, cfg.out_channel};
            rsp_in.out_first  = {1'b0, q_data.ctl_num};
            rsp_in.out_length = LEN_FULL;
         end
         KIND_PROGRAM: begin
            rsp_in.out_status = {NIB_PROGRAM, cfg.out_channel};
            rsp_in.out_second = 8'd0;
            rsp_in.out_length = LEN_PROGRAM;
         end
         default: begin
            rsp_in.out_status = q_data.item.status;
         end
      endcase
   end

   assign rsp_vld_in = q_pop || (rsp_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/midi_zone_filter_remap.sv @@
// A transaction accepted on req passes through the front stage register, the queue and
// the result register before it is offered on rsp.
// Throughput: one transaction per cycle, held up only by rsp_stall backing up the queue.
// Reset (synchronous, active high) empties the pipeline, restores the register defaults,
// clears the last program to zero and returns the controller map to identity at once.
// Depends on mzfr_pkg, mzfr_front, mzfr_queue and mzfr_back.
module midi_zone_filter_remap import mzfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Input transaction channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // Result transaction channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // Register port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Configuration registers. Software is to write them only while the block is
   // idle; the block itself does not enforce this. Both pipeline halves read them live.
   logic              active_ff;
   logic [6:0]        note_low_ff;
   logic [6:0]        note_high_ff;
   logic [6:0]        vel_ovr_ff;
   logic signed [5:0] transpose_ff;
   logic [3:0]        out_chan_ff;
   logic [6:0]        program_ff;
   logic              csr_wr;
   csr_index_type     csr_idx;
   cfg_type           cfg;

   // Front-to-back queue signals.
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   job_type q_wr_data;
   job_type q_rd_data;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b1;
         note_low_ff  <= 7'd0;
         note_high_ff <= 7'd127;
         vel_ovr_ff   <= 7'd0;
         transpose_ff <= 6'sd0;
         out_chan_ff  <= 4'd0;
         program_ff   <= 7'd0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_ACTIVE:    active_ff    <= pwdata[0];
            CSR_NOTE_LOW:  note_low_ff  <= pwdata[6:0];
            CSR_NOTE_HIGH: note_high_ff <= pwdata[6:0];
            CSR_VEL_OVR:   vel_ovr_ff   <= pwdata[6:0];
            CSR_TRANSPOSE: transpose_ff <= pwdata[5:0];
            CSR_OUT_CHAN:  out_chan_ff  <= pwdata[3:0];
            CSR_PROGRAM:   program_ff   <= pwdata[6:0];
            default:       active_ff    <= active_ff;
         endcase
      end
   end

   // Register reads return zero-extended values; unused addresses read zero.
   always_comb begin
      case (csr_idx)
         CSR_ACTIVE:    prdata = {31'd0, active_ff};
         CSR_NOTE_LOW:  prdata = {25'd0, note_low_ff};
         CSR_NOTE_HIGH: prdata = {25'd0, note_high_ff};
         CSR_VEL_OVR:   prdata = {25'd0, vel_ovr_ff};
         CSR_TRANSPOSE: prdata = {26'd0, transpose_ff};
         CSR_OUT_CHAN:  prdata = {28'd0, out_chan_ff};
         CSR_PROGRAM:   prdata = {25'd0, program_ff};
         default:       prdata = 32'd0;
      endcase
   end

   always_comb begin
      cfg.active            = active_ff;
      cfg.note_low          = note_low_ff;
      cfg.note_high         = note_high_ff;
      cfg.velocity_override = vel_ovr_ff;
      cfg.transpose         = transpose_ff;
      cfg.out_channel       = out_chan_ff;
      cfg.program_cfg       = program_ff;
   end

   // The front end decides whether a transaction produces a message at all,
   // applies map writes and period starts, and looks up the controller map.
   // Only transactions that will produce a message enter the queue.
   mzfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   // Two-entry queue so the front keeps accepting while the result side stalls, until it fills.
   mzfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   // The back end rewrites channel, note, velocity and controller number and registers the result.
   mzfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ bench/midi_zone_filter_remap_tb.sv @@
// Self-checking testbench for the MIDI zone filter and remap block.
// Needs mzfr_pkg and midi_zone_filter_remap; it predicts every result on its own.
`timescale 1ns / 1ps

module midi_zone_filter_remap_tb;
   import mzfr_pkg::*;

   // Opcode 3 has no meaning in the block; it must be swallowed silently.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int ITEMS_PER_PHASE = 150;
   localparam int RANDOM_PHASES   = 9;
   localparam int LONG_HOLD       = 200;
   localparam int IDLE_LIMIT      = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int REPORT_LIMIT    = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   midi_zone_filter_remap uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The zone as the testbench believes it to be: register copy, the program
   // last sent and the controller renumbering table.
   cfg_type    zone_cfg;
   logic [6:0] last_program;
   logic [6:0] ctl_map [MAP_DEPTH];

   req_type pending_msgs [$];
   rsp_type expected_msgs [$];

   // Handshake outcomes of the latest rising edge, read by the falling-edge drivers.
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;

   int queued_count   = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int program_count  = 0;
   int setting_count  = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;

   int  send_max_gap  = 0;
   int  recv_max_gap  = 0;
   int  gap_left      = 0;
   int  stall_left    = 0;
   int  hold_left     = 0;
   bit  long_hold_req = 1'b0;
   bit  long_hold_done = 1'b0;

   // Works out what one transaction does to the zone and whether it produces a
   // result. State is updated here, so it must be called once per accepted item.
   function automatic bit zone_predict(input req_type m, output rsp_type r);
      logic [3:0] nib;
      int         tr;
      int         shifted;
      bit         on;
      nib = m.status_byte[7:4];
      tr = int'($signed(zone_cfg.transpose));
      r = '0;
      zone_predict = 1'b0;
      if (m.opcode == OP_MAP) begin
         // Map writes land even while the zone is disabled.
         ctl_map[m.map_source] = m.map_target;
      end else if (m.opcode == OP_PERIOD) begin
         if (zone_cfg.active && last_program != zone_cfg.program_cfg) begin
            last_program = zone_cfg.program_cfg;
            r.out_status = {NIB_PROGRAM, zone_cfg.out_channel};
            r.out_first  = {1'b0, zone_cfg.program_cfg};
            r.out_second = 8'h00;
            r.out_length = LEN_PROGRAM;
            zone_predict = 1'b1;
         end
      end else if (m.opcode == OP_MIDI && zone_cfg.active &&
                   m.msg_length != 0 && m.msg_length <= MAX_MSG_LEN) begin
         if (nib == NIB_NOTE_ON || nib == NIB_NOTE_OFF) begin
            // The range test uses the whole byte, so notes above 127 never pass.
            if (m.first_data >= {1'b0, zone_cfg.note_low} &&
                m.first_data <= {1'b0, zone_cfg.note_high}) begin
               on = (nib == NIB_NOTE_ON) && (m.second_data != 8'h00);
               shifted = int'(m.first_data) + tr;
               if (shifted < 0) shifted = 0;
               if (shifted > 127) shifted = 127;
               r.out_status = {(on ? NIB_NOTE_ON : NIB_NOTE_OFF), zone_cfg.out_channel};
               r.out_first  = shifted[7:0];
               r.out_second = (zone_cfg.velocity_override != 0) ?
                              {1'b0, zone_cfg.velocity_override} : m.second_data;
               r.out_length = LEN_FULL;
               zone_predict = 1'b1;
            end
         end else if (nib == NIB_CTRL) begin
            r.out_status = {NIB_CTRL, zone_cfg.out_channel};
            r.out_first  = {1'b0, ctl_map[m.first_data[6:0]]};
            r.out_second = m.second_data;
            r.out_length = LEN_FULL;
            zone_predict = 1'b1;
         end else begin
            // Anything else goes through as is, with unused bytes cleared.
            r.out_status = m.status_byte;
            r.out_first  = (m.msg_length >= 2) ? m.first_data : 8'h00;
            r.out_second = (m.msg_length >= 3) ? m.second_data : 8'h00;
            r.out_length = m.msg_length[1:0];
            zone_predict = 1'b1;
         end
      end
   endfunction

   // Input driver. A transaction that is stalled keeps its payload; after each
   // accepted one the driver waits a drawn number of cycles before the next.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_fire)) begin
         if (req_valid) gap_left = $urandom_range(0, send_max_gap);
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_msgs.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_msgs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver. Besides the per-result stall it can hold off once for a
   // long stretch so that the pipeline backs up into req_stall.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_req && !long_hold_done) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (rsp_fire) stall_left = $urandom_range(0, recv_max_gap);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: checks results against the oldest expectation, predicts every
   // accepted input transaction, and runs the watchdog on handshake activity.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      rsp_type pred;
      bit      bad;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (rsp_fire) begin
         if (expected_msgs.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
               $display("[%0t] result with nothing expected: status %h first %h second %h len %0d",
                        $realtime, rsp_data.out_status, rsp_data.out_first,
                        rsp_data.out_second, rsp_data.out_length);
         end else begin
            exp_rsp = expected_msgs.pop_front();
            bad = (rsp_data.out_status !== exp_rsp.out_status) ||
                  (rsp_data.out_first  !== exp_rsp.out_first)  ||
                  (rsp_data.out_second !== exp_rsp.out_second) ||
                  (rsp_data.out_length !== exp_rsp.out_length);
            if (bad) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_LIMIT)
                  $display("[%0t] result %0d: expected %h %h %h len %0d, got %h %h %h len %0d",
                           $realtime, checked_count, exp_rsp.out_status, exp_rsp.out_first,
                           exp_rsp.out_second, exp_rsp.out_length, rsp_data.out_status,
                           rsp_data.out_first, rsp_data.out_second, rsp_data.out_length);
            end
            checked_count = checked_count + 1;
         end
      end
      if (req_fire) begin
         accepted_count = accepted_count + 1;
         if (zone_predict(req_data, pred)) begin
            expected_msgs.push_back(pred);
            if (req_data.opcode == OP_PERIOD) program_count = program_count + 1;
         end
      end
      if (req_fire || rsp_fire || reset) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, expected_msgs.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic req_type midi_item(input logic [7:0] st, input logic [7:0] d1,
                                         input logic [7:0] d2, input logic [3:0] len);
      midi_item = '0;
      midi_item.opcode      = OP_MIDI;
      midi_item.status_byte = st;
      midi_item.first_data  = d1;
      midi_item.second_data = d2;
      midi_item.msg_length  = len;
   endfunction

   function automatic req_type map_item(input logic [6:0] src, input logic [6:0] tgt);
      map_item = '0;
      map_item.opcode     = OP_MAP;
      map_item.map_source = src;
      map_item.map_target = tgt;
   endfunction

   function automatic req_type op_item(input logic [1:0] op);
      op_item = '0;
      op_item.opcode = op;
   endfunction

   // Half the time one of the two ends of a range, otherwise anywhere inside it.
   function automatic int pick(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) pick = lo;
      else if (r == 1) pick = hi;
      else pick = lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Random traffic is mostly well-formed notes and controllers with random
   // content; the rest is map writes, period starts, odd lengths and junk.
   function automatic req_type random_item();
      req_type m;
      int      roll;
      int      sub;
      m.opcode      = 2'($urandom_range(0, 3));
      m.status_byte = 8'($urandom_range(0, 255));
      m.first_data  = 8'($urandom_range(0, 255));
      m.second_data = 8'($urandom_range(0, 255));
      m.msg_length  = 4'($urandom_range(0, 15));
      m.map_source  = 7'($urandom_range(0, 127));
      m.map_target  = 7'($urandom_range(0, 127));
      roll = $urandom_range(0, 99);
      if (roll < 8) m.opcode = OP_MAP;
      else if (roll < 18) m.opcode = OP_PERIOD;
      else if (roll < 21) m.opcode = OP_UNUSED;
      else begin
         m.opcode = OP_MIDI;
         sub = $urandom_range(0, 99);
         if (sub < 50) begin
            m.status_byte[7:4] = $urandom_range(0, 1) ? NIB_NOTE_ON : NIB_NOTE_OFF;
            if ($urandom_range(0, 3) != 0 && zone_cfg.note_low <= zone_cfg.note_high)
               m.first_data = 8'($urandom_range(zone_cfg.note_low, zone_cfg.note_high));
            sub = $urandom_range(0, 99);
            if (sub < 10) m.second_data = 8'h00;
            else if (sub < 85) m.second_data = 8'($urandom_range(1, 127));
         end else if (sub < 70) begin
            m.status_byte[7:4] = NIB_CTRL;
         end
         if ($urandom_range(0, 99) < 75)
            m.msg_length = (m.status_byte[7:4] == NIB_NOTE_ON ||
                            m.status_byte[7:4] == NIB_NOTE_OFF ||
                            m.status_byte[7:4] == NIB_CTRL) ? 4'd3 :
                           4'($urandom_range(1, 3));
      end
      random_item = m;
   endfunction

   task automatic send(input req_type m);
      pending_msgs.push_back(m);
      queued_count = queued_count + 1;
   endtask

   // Waits until every queued transaction has been taken and every result has
   // come back, then lets the pipeline settle, since items like map writes or
   // silent period starts may still be in flight.
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_msgs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready is seen.
   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_ACTIVE:    zone_cfg.active            = val[0];
         CSR_NOTE_LOW:  zone_cfg.note_low          = val[6:0];
         CSR_NOTE_HIGH: zone_cfg.note_high         = val[6:0];
         CSR_VEL_OVR:   zone_cfg.velocity_override = val[6:0];
         CSR_TRANSPOSE: zone_cfg.transpose         = val[5:0];
         CSR_OUT_CHAN:  zone_cfg.out_channel       = val[3:0];
         CSR_PROGRAM:   zone_cfg.program_cfg       = val[6:0];
         default: ;
      endcase
   endtask

   task automatic zone_setup(input bit act, input int lo, input int hi, input int vel,
                             input int tr, input int ch, input int prog);
      csr_write(CSR_ACTIVE, {31'b0, act});
      csr_write(CSR_NOTE_LOW, lo);
      csr_write(CSR_NOTE_HIGH, hi);
      csr_write(CSR_VEL_OVR, vel);
      csr_write(CSR_TRANSPOSE, tr & 32'h3F);
      csr_write(CSR_OUT_CHAN, ch);
      csr_write(CSR_PROGRAM, prog);
      setting_count = setting_count + 1;
   endtask

   initial begin
      zone_cfg = '0;
      zone_cfg.active    = 1'b1;
      zone_cfg.note_high = 7'd127;
      last_program = '0;
      for (int i = 0; i < MAP_DEPTH; i++) ctl_map[i] = i[6:0];

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset configuration: note on and off forms,
      // range edges, controller renumbering, pass-through lengths, long, empty
      // and short messages, and the unused opcode.
      send(midi_item(8'h93, 8'd60, 8'd100, 4'd3));
      send(midi_item(8'h90, 8'd64, 8'd0, 4'd3));
      send(midi_item(8'h85, 8'd0, 8'd127, 4'd3));
      send(midi_item(8'h9F, 8'd127, 8'hFF, 4'd3));
      send(midi_item(8'h90, 8'd200, 8'd50, 4'd3));
      send(midi_item(8'hB2, 8'hFF, 8'hFF, 4'd3));
      send(map_item(7'd7, 7'd100));
      send(midi_item(8'hB0, 8'd7, 8'd64, 4'd3));
      send(op_item(OP_PERIOD));
      send(midi_item(8'hF8, 8'h11, 8'h22, 4'd1));
      send(midi_item(8'hC5, 8'h33, 8'h44, 4'd2));
      send(midi_item(8'hE0, 8'h55, 8'h66, 4'd3));
      send(midi_item(8'h00, 8'h7F, 8'h80, 4'd3));
      send(midi_item(8'h90, 8'd60, 8'd100, 4'd4));
      send(midi_item(8'h90, 8'd60, 8'd100, 4'd15));
      send(midi_item(8'hF0, 8'd1, 8'd2, 4'd0));
      send(midi_item(8'h92, 8'd61, 8'd90, 4'd1));
      send(op_item(OP_UNUSED));
      wait_idle();

      // Upper extremes: narrow range, transpose up by 24, fixed velocity, last
      // channel and a new program, which the first period start must send.
      zone_setup(1'b1, 10, 100, 127, 24, 15, 127);
      send(midi_item(8'h90, 8'd100, 8'd1, 4'd3));
      send(midi_item(8'h80, 8'd10, 8'd0, 4'd3));
      send(midi_item(8'h90, 8'd9, 8'd5, 4'd3));
      send(midi_item(8'h90, 8'd101, 8'd5, 4'd3));
      send(op_item(OP_PERIOD));
      send(op_item(OP_PERIOD));
      wait_idle();

      // Transpose down by 24 clamps low notes at zero.
      csr_write(CSR_TRANSPOSE, 32'(-24) & 32'h3F);
      send(midi_item(8'h90, 8'd10, 8'd5, 4'd3));
      wait_idle();

      // A disabled zone stays silent but still takes map writes.
      csr_write(CSR_ACTIVE, 32'd0);
      csr_write(CSR_PROGRAM, 32'd3);
      send(midi_item(8'h90, 8'd50, 8'd5, 4'd3));
      send(op_item(OP_PERIOD));
      send(map_item(7'd7, 7'd3));
      wait_idle();
      csr_write(CSR_ACTIVE, 32'd1);
      send(midi_item(8'hB0, 8'd7, 8'd1, 4'd3));
      wait_idle();

      // Random phases, each under its own register setting and idle pattern.
      // The first two take the lower and then the upper ends of most registers, with transpose at -24 and +24.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) zone_setup(1'b1, 0, 127, 0, -24, 0, 0);
         else if (phase == 1) zone_setup(1'b1, 127, 127, 127, 24, 15, 127);
         else zone_setup($urandom_range(0, 7) != 0, pick(0, 127), pick(0, 127),
                         pick(0, 127), pick(-24, 24), pick(0, 15), pick(0, 127));
         case (phase % 3)
            0: send_max_gap = 0;
            1: send_max_gap = 10;
            default: send_max_gap = 3;
         endcase
         case ((phase + 1) % 3)
            0: recv_max_gap = 0;
            1: recv_max_gap = 10;
            default: recv_max_gap = 3;
         endcase
         // One phase keeps the sender busy while the receiver holds off.
         if (phase == 2) begin
            send_max_gap = 0;
            long_hold_req = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send(random_item());
         wait_idle();
      end

      repeat (20) @(negedge clock);
      $display("Run covered %0d input transactions and %0d checked results,",
               accepted_count, checked_count);
      $display("including %0d program changes, over %0d register settings.",
               program_count, setting_count);
      if (mismatches == 0 && expected_msgs.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches,
                  expected_msgs.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ midi_zone_filter_remap.f @@
rtl/core/mzfr_pkg.sv
rtl/core/mzfr_front.sv
rtl/core/mzfr_queue.sv
rtl/core/mzfr_back.sv
rtl/core/midi_zone_filter_remap.sv
bench/midi_zone_filter_remap_tb.sv
